// ===== rtl/core/pcr_pkg.sv =====
// Shared widths, codes and controller/datapath command types for the correlation block.
package pcr_pkg;

  localparam int FIELD_W   = 16;
  localparam int MSE_W     = 32;
  localparam int SP_W      = 33;
  localparam int SQ_W      = 47;
  localparam int SSE_W     = 49;
  localparam int MUL_W     = 64;
  localparam int DIG_W     = 16;
  localparam int PROD_W    = 128;
  localparam int SRCH_W    = 160;
  localparam int K_W       = 15;
  localparam int STEP_W    = 6;
  localparam int MUL_LAST  = 3;
  localparam int DIV_LAST  = SSE_W - 1;
  localparam int SQRT_LAST = 15;
  localparam int SRCH_TOP  = 13;
  localparam int L_SHIFT   = 30;

  localparam logic [2:0] JOB_NPP = 3'd0;
  localparam logic [2:0] JOB_PP  = 3'd1;
  localparam logic [2:0] JOB_NOO = 3'd2;
  localparam logic [2:0] JOB_OO  = 3'd3;
  localparam logic [2:0] JOB_NPO = 3'd4;
  localparam logic [2:0] JOB_PO  = 3'd5;
  localparam logic [2:0] JOB_AB  = 3'd6;
  localparam logic [2:0] JOB_CC  = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_MUL,
    OP_MWR,
    OP_ABC,
    OP_DIV,
    OP_SQRT,
    OP_SINIT,
    OP_SCAND,
    OP_SCMP,
    OP_CLR
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MWR,
    ST_ABC,
    ST_DIV,
    ST_SQRT,
    ST_SINIT,
    ST_SCAND,
    ST_SCMP,
    ST_OUT
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [2:0]        job;
    logic [1:0]        digit;
    logic [STEP_W-1:0] step;
  } cmd_t;

endpackage

// ===== rtl/core/pcr_if.sv =====
// Stream interfaces for sample pairs and for result items.
interface pcr_in_if import pcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] real_value;
  logic signed [FIELD_W-1:0] predicted_value;
  logic                      last_pair;
  modport source (output valid, real_value, predicted_value, last_pair, input ready);
  modport sink   (input valid, real_value, predicted_value, last_pair, output ready);
endinterface

interface pcr_out_if import pcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] correlation;
  logic [FIELD_W-1:0]        root_mean_square_error;
  logic [MSE_W-1:0]          mean_square_error;
  logic                      status;
  modport source (output valid, correlation, root_mean_square_error, mean_square_error, status,
                  input ready);
  modport sink   (input valid, correlation, root_mean_square_error, mean_square_error, status,
                  output ready);
endinterface

// ===== rtl/core/pearson_correlation_rmse.sv =====
// Top level: Pearson correlation and error statistics over a set of sample pairs.
//
//   channel  dir  payload                                             transfer when
//   in_ch    in   real_value, predicted_value, last_pair              valid & ready
//   out_ch   out  correlation, root_mean_square_error,                valid & ready
//                 mean_square_error, status
//
// Cycles: one pair per cycle while a set accumulates. The pair marked last
// starts the end-of-set sequence of the products on the 64x16 digit
// multiplier, 1 combine, 49 divider steps, 16 square root steps, 1 search
// setup and the search passes, after which the result is offered on out_ch.
// Reset clears the sums and the sequencer; no clearing pass is needed.
// in_ch.ready drops from the last pair until the result transfers; a stalled
// result holds in its registers, and the sums clear on its transfer.
module pearson_correlation_rmse import pcr_pkg::*; #(
  parameter int MAX_PAIRS   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  pcr_in_if.sink    in_ch,
  pcr_out_if.source out_ch
);

  cmd_t cmd;

  // sequence accumulation and the end-of-set math
  pcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.last_pair),
    .out_ready_i (out_ch.ready),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd)
  );

  // hold the sums and compute the result fields
  pcr_dp #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (cmd),
    .real_value_i             (in_ch.real_value),
    .predicted_value_i        (in_ch.predicted_value),
    .correlation_o            (out_ch.correlation),
    .root_mean_square_error_o (out_ch.root_mean_square_error),
    .mean_square_error_o      (out_ch.mean_square_error),
    .status_o                 (out_ch.status)
  );

endmodule

// ===== rtl/core/pcr_ctrl.sv =====
// Sequencer that steps the datapath through accumulation and the end-of-set math.
module pcr_ctrl import pcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  st_e               state_q, state_d;
  logic [2:0]        job_q, job_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_MUL;
          job_d   = JOB_NPP;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_q == STEP_W'(MUL_LAST)) state_d = ST_MWR;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_MWR: begin
        cnt_d = '0;
        if (job_q == JOB_PO) begin
          state_d = ST_ABC;
        end else if (job_q == JOB_CC) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_MUL;
          job_d   = job_q + 1'b1;
        end
      end
      ST_ABC: begin
        state_d = ST_MUL;
        job_d   = JOB_AB;
        cnt_d   = '0;
      end
      ST_DIV: begin
        if (cnt_q == STEP_W'(DIV_LAST)) begin
          state_d = ST_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_q == STEP_W'(SQRT_LAST)) state_d = ST_SINIT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_SINIT: begin
        state_d = ST_SCAND;
        cnt_d   = STEP_W'(SRCH_TOP);
      end
      ST_SCAND: state_d = ST_SCMP;
      ST_SCMP: begin
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SCAND;
          cnt_d   = cnt_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.job   = job_q;
    cmd_o.digit = cnt_q[1:0];
    cmd_o.step  = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_ACC;
      end
      ST_MUL:   cmd_o.op = OP_MUL;
      ST_MWR:   cmd_o.op = OP_MWR;
      ST_ABC:   cmd_o.op = OP_ABC;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_SQRT:  cmd_o.op = OP_SQRT;
      ST_SINIT: cmd_o.op = OP_SINIT;
      ST_SCAND: cmd_o.op = OP_SCAND;
      ST_SCMP:  cmd_o.op = OP_SCMP;
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) cmd_o.op = OP_CLR;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/pcr_dp.sv =====
// Datapath: running sums, 64x16 digit multiplier, divider, square root and coefficient search.
module pcr_dp import pcr_pkg::*; #(
  parameter int MAX_PAIRS   = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  input  logic signed [FIELD_W-1:0] real_value_i,
  input  logic signed [FIELD_W-1:0] predicted_value_i,
  output logic signed [FIELD_W-1:0] correlation_o,
  output logic [FIELD_W-1:0]        root_mean_square_error_o,
  output logic [MSE_W-1:0]          mean_square_error_o,
  output logic                      status_o
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int SB    = SAMPLE_BITS;

  // running sums
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SP_W-1:0]  sp_q, so_q;
  logic signed [SQ_W-1:0]  spp_q, soo_q, spo_q;
  logic signed [SSE_W-1:0] sse_q;

  logic signed [SB-1:0]    r_s, p_s;
  logic signed [SB:0]      e_s;
  logic signed [2*SB-1:0]  pp_s, rr_s, pr_s;
  logic signed [2*SB+1:0]  ee_s;

  assign r_s  = real_value_i[SB-1:0];
  assign p_s  = predicted_value_i[SB-1:0];
  assign e_s  = (SB+1)'(p_s) - (SB+1)'(r_s);
  assign pp_s = p_s * p_s;
  assign rr_s = r_s * r_s;
  assign pr_s = p_s * r_s;
  assign ee_s = e_s * e_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sp_q  <= '0;
      so_q  <= '0;
      spp_q <= '0;
      soo_q <= '0;
      spo_q <= '0;
      sse_q <= '0;
    end else if (cmd_i.op == OP_CLR) begin
      cnt_q <= '0;
      sp_q  <= '0;
      so_q  <= '0;
      spp_q <= '0;
      soo_q <= '0;
      spo_q <= '0;
      sse_q <= '0;
    end else if (cmd_i.op == OP_ACC && cnt_q < CNT_W'(MAX_PAIRS)) begin
      cnt_q <= cnt_q + 1'b1;
      sp_q  <= sp_q + SP_W'(p_s);
      so_q  <= so_q + SP_W'(r_s);
      spp_q <= spp_q + SQ_W'(pp_s);
      soo_q <= soo_q + SQ_W'(rr_s);
      spo_q <= spo_q + SQ_W'(pr_s);
      sse_q <= sse_q + SSE_W'(ee_s);
    end
  end

  // magnitudes of the signed sums
  logic [SP_W-1:0] sp_mag, so_mag;
  logic [SQ_W-1:0] spo_mag;
  assign sp_mag  = sp_q[SP_W-1] ? -sp_q : sp_q;
  assign so_mag  = so_q[SP_W-1] ? -so_q : so_q;
  assign spo_mag = spo_q[SQ_W-1] ? -spo_q : spo_q;

  // end-of-set registers
  logic [MUL_W-1:0]  tnp_q, tpp_q, tno_q, too_q, tnpo_q, tpo_q;
  logic [MUL_W-1:0]  a_q, b_q, cmag_q;
  logic              cneg_q, degen_q;
  logic [PROD_W-1:0] acc_q, p_q;
  logic [SRCH_W-1:0] l_q;

  // digit multiplier
  logic [MUL_W-1:0]       ma, mb;
  logic [DIG_W-1:0]       mb_dig;
  logic [MUL_W+DIG_W-1:0] part;

  always_comb begin
    case (cmd_i.job)
      JOB_NPP: begin ma = MUL_W'(cnt_q);   mb = MUL_W'($unsigned(spp_q)); end
      JOB_PP:  begin ma = MUL_W'(sp_mag);  mb = MUL_W'(sp_mag);           end
      JOB_NOO: begin ma = MUL_W'(cnt_q);   mb = MUL_W'($unsigned(soo_q)); end
      JOB_OO:  begin ma = MUL_W'(so_mag);  mb = MUL_W'(so_mag);           end
      JOB_NPO: begin ma = MUL_W'(cnt_q);   mb = MUL_W'(spo_mag);          end
      JOB_PO:  begin ma = MUL_W'(sp_mag);  mb = MUL_W'(so_mag);           end
      JOB_AB:  begin ma = a_q;             mb = b_q;                      end
      default: begin ma = cmag_q;          mb = cmag_q;                   end
    endcase
  end

  assign mb_dig = mb[{cmd_i.digit, 4'b0000} +: DIG_W];
  assign part   = ma * mb_dig;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MUL) begin
      acc_q <= ((cmd_i.digit == 2'd0) ? '0 : acc_q)
             + (PROD_W'(part) << {cmd_i.digit, 4'b0000});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MWR) begin
      case (cmd_i.job)
        JOB_NPP: tnp_q  <= acc_q[MUL_W-1:0];
        JOB_PP:  tpp_q  <= acc_q[MUL_W-1:0];
        JOB_NOO: tno_q  <= acc_q[MUL_W-1:0];
        JOB_OO:  too_q  <= acc_q[MUL_W-1:0];
        JOB_NPO: tnpo_q <= acc_q[MUL_W-1:0];
        JOB_PO:  tpo_q  <= acc_q[MUL_W-1:0];
        JOB_AB:  p_q    <= acc_q;
        default: l_q    <= SRCH_W'(acc_q) << L_SHIFT;
      endcase
    end
  end

  // variance terms and signed covariance
  logic [MUL_W-1:0] a_v, b_v;
  logic [MUL_W:0]   t1, t2, c_v;
  assign a_v = tnp_q - tpp_q;
  assign b_v = tno_q - too_q;
  assign t1  = spo_q[SQ_W-1] ? -{1'b0, tnpo_q} : {1'b0, tnpo_q};
  assign t2  = (sp_q[SP_W-1] ^ so_q[SP_W-1]) ? -{1'b0, tpo_q} : {1'b0, tpo_q};
  assign c_v = t1 - t2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ABC) begin
      a_q     <= a_v;
      b_q     <= b_v;
      cneg_q  <= c_v[MUL_W];
      cmag_q  <= c_v[MUL_W] ? MUL_W'(-c_v) : c_v[MUL_W-1:0];
      degen_q <= (a_v == '0) || (b_v == '0);
    end
  end

  // restoring divider, one quotient bit a step
  logic [CNT_W-1:0]  rem_q;
  logic [SSE_W-1:0]  dvd_q, quo_q;
  logic [CNT_W:0]    rem_t;
  logic              div_ge;
  assign rem_t  = {rem_q, dvd_q[SSE_W-1]};
  assign div_ge = rem_t >= {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ABC) begin
      rem_q <= '0;
      dvd_q <= $unsigned(sse_q);
      quo_q <= '0;
    end else if (cmd_i.op == OP_DIV) begin
      rem_q <= div_ge ? CNT_W'(rem_t - {1'b0, cnt_q}) : rem_t[CNT_W-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[SSE_W-2:0], div_ge};
    end
  end

  // integer square root, two radicand bits a step
  logic [MSE_W-1:0] sx_q, root_q, x_in, root_in, bitv, rb;
  assign x_in    = (cmd_i.step == '0) ? quo_q[MSE_W-1:0] : sx_q;
  assign root_in = (cmd_i.step == '0) ? '0 : root_q;
  assign bitv    = 32'h4000_0000 >> {cmd_i.step, 1'b0};
  assign rb      = root_in + bitv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SQRT) begin
      if (x_in >= rb) begin
        sx_q   <= x_in - rb;
        root_q <= (root_in >> 1) + bitv;
      end else begin
        sx_q   <= x_in;
        root_q <= root_in >> 1;
      end
    end
  end

  // coefficient search: X = v^2*P, Y = v*P for v = 2k-1, one bit of k a pass
  logic [SRCH_W-1:0] xs_q, ys_q, xc_q, yc_q, pe;
  logic [K_W-1:0]    k_q, kc_q;
  logic              ok_q;
  logic [3:0]        j;
  assign pe = SRCH_W'(p_q);
  assign j  = cmd_i.step[3:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SINIT: begin
        xs_q <= pe;
        ys_q <= pe;
        k_q  <= K_W'(1);
        ok_q <= pe <= l_q;
      end
      OP_SCAND: begin
        xc_q <= xs_q + (ys_q << ({1'b0, j} + 5'd2)) + (pe << ({j, 1'b0} + 5'd2));
        yc_q <= ys_q + (pe << ({1'b0, j} + 5'd1));
        kc_q <= k_q + (K_W'(1) << j);
      end
      OP_SCMP: begin
        if (xc_q <= l_q) begin
          xs_q <= xc_q;
          ys_q <= yc_q;
          k_q  <= kc_q;
        end
      end
      default: begin
      end
    endcase
  end

  logic [K_W-1:0] q_v;
  assign q_v = (degen_q || !ok_q) ? '0 : k_q;

  assign correlation_o            = cneg_q ? -FIELD_W'(q_v) : FIELD_W'(q_v);
  assign root_mean_square_error_o = root_q[FIELD_W-1:0];
  assign mean_square_error_o      = quo_q[MSE_W-1:0];
  assign status_o                 = degen_q;

endmodule

// ===== rtl/core/pcr_checker.sv =====
// Port-level checks for the correlation block, bound to the top level.
module pcr_checker import pcr_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [FIELD_W-1:0] correlation_i,
  input logic                      status_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input open while a result waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input not closed after last pair");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i)
    else $error("input not reopened after result transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> correlation_i == '0)
    else $error("degenerate result with nonzero correlation");

endmodule

bind pearson_correlation_rmse pcr_checker u_pcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .in_last_i     (in_ch.last_pair),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .correlation_i (out_ch.correlation),
  .status_i      (out_ch.status)
);

// ===== tb/pearson_correlation_rmse_tb.sv =====
// Self-checking testbench for the Pearson correlation and error statistics block.
module pearson_correlation_rmse_tb;
  import pcr_pkg::*;

  localparam int  MAX_PAIRS   = 65536;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  TAIL_CYCLES = 200;

  typedef struct {
    logic signed [FIELD_W-1:0] correlation;
    logic [FIELD_W-1:0]        root_mean_square_error;
    logic [MSE_W-1:0]          mean_square_error;
    logic                      status;
  } stats_t;

  typedef struct {
    logic signed [FIELD_W-1:0] real_value;
    logic signed [FIELD_W-1:0] predicted_value;
    logic                      last_pair;
    bit                        typed;
    stats_t                    typed_stats;
  } pair_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcr_in_if  in_ch();
  pcr_out_if out_ch();

  pearson_correlation_rmse #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // Running sums of the set under way, kept by the predictor.
  bit [63:0] set_pairs;
  bit [63:0] set_sum_pred, set_sum_obs, set_sum_pred_sq, set_sum_obs_sq;
  bit [63:0] set_sum_cross, set_sum_sq_err;

  stats_t pending_stats[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     idling_on = 1'b0;
  int     stall_left = 0;

  function automatic void clear_sums();
    set_pairs = '0;
    set_sum_pred = '0;
    set_sum_obs = '0;
    set_sum_pred_sq = '0;
    set_sum_obs_sq = '0;
    set_sum_cross = '0;
    set_sum_sq_err = '0;
  endfunction

  function automatic bit [63:0] abs64(bit [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic bit [15:0] floor_sqrt(bit [31:0] x);
    bit [15:0] root;
    bit [15:0] trial;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (16'd1 << i);
      if ({32'd0, trial} * {32'd0, trial} <= {32'd0, x}) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted pair into the sums; return 1 with the set statistics on the marked pair.
  function automatic bit fold_pair(logic signed [FIELD_W-1:0] obs,
                                   logic signed [FIELD_W-1:0] pred,
                                   logic last, output stats_t stats);
    bit [63:0]  o, p, e, mse, a, b, cu, cmag, lo, hi, mid, odd;
    bit [191:0] ab_prod, c_side, rhs;
    bit         neg, degenerate;
    o = 64'(signed'(obs));
    p = 64'(signed'(pred));
    if (set_pairs < MAX_PAIRS) begin
      e = p - o;
      set_pairs++;
      set_sum_pred += p;
      set_sum_obs += o;
      set_sum_pred_sq += p * p;
      set_sum_obs_sq += o * o;
      set_sum_cross += p * o;
      set_sum_sq_err += e * e;
    end
    if (!last) return 1'b0;

    mse = (set_pairs != 0) ? set_sum_sq_err / set_pairs : 64'd0;
    mse &= 64'hFFFF_FFFF;
    a = set_pairs * set_sum_pred_sq - abs64(set_sum_pred) * abs64(set_sum_pred);
    b = set_pairs * set_sum_obs_sq - abs64(set_sum_obs) * abs64(set_sum_obs);
    cu = set_pairs * set_sum_cross - set_sum_pred * set_sum_obs;
    neg = cu[63];
    cmag = neg ? -cu : cu;
    degenerate = (a == 0) || (b == 0);
    lo = 0;
    if (!degenerate) begin
      // largest k with (2k-1)^2 * A * B <= 2^30 * C^2
      ab_prod = {128'd0, a} * {128'd0, b};
      c_side = ({128'd0, cmag} * {128'd0, cmag}) << 30;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 2 * mid - 1;
        rhs = {128'd0, odd * odd} * ab_prod;
        if (rhs <= c_side) lo = mid;
        else hi = mid - 1;
      end
    end
    stats.correlation = neg ? -lo[15:0] : lo[15:0];
    stats.root_mean_square_error = floor_sqrt(mse[31:0]);
    stats.mean_square_error = mse[31:0];
    stats.status = degenerate;
    clear_sums();
    return 1'b1;
  endfunction

  // Hold the pair until it transfers, with an optional idle burst in front.
  task automatic send_pair(logic signed [FIELD_W-1:0] obs, logic signed [FIELD_W-1:0] pred,
                           logic last, bit typed, stats_t typed_stats);
    stats_t predicted;
    int     gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.real_value <= obs;
    in_ch.predicted_value <= pred;
    in_ch.last_pair <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (fold_pair(obs, pred, last, predicted))
      pending_stats.push_back(typed ? typed_stats : predicted);
  endtask

  task automatic send_set(int pairs, int style);
    logic signed [FIELD_W-1:0] obs, pred, base;
    stats_t none;
    base = 16'($urandom);
    for (int i = 0; i < pairs; i++) begin
      case (style)
        0: begin
          obs = 16'($urandom);
          pred = 16'($urandom);
        end
        1: begin  // predictions that track the observation closely
          obs = 16'($urandom);
          pred = obs + $signed(16'($urandom_range(0, 64))) - 16'sd32;
        end
        2: begin  // constant observation, varying prediction
          obs = base;
          pred = 16'($urandom_range(0, 255));
        end
        3: begin  // samples pinned to the range ends
          obs = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          pred = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        default: begin  // small values, inverse relation
          obs = $signed(16'($urandom_range(0, 40))) - 16'sd20;
          pred = -obs + $signed(16'($urandom_range(0, 6))) - 16'sd3;
        end
      endcase
      send_pair(obs, pred, i == pairs - 1, 1'b0, none);
    end
  endtask

  // Sink side: drop ready in bursts of random length while idling is on.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result that transfers with the oldest expectation.
  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_stats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: corr %0d rmse %0d mse %0d status %0d",
                   out_ch.correlation, out_ch.root_mean_square_error,
                   out_ch.mean_square_error, out_ch.status);
      end else begin
        want = pending_stats.pop_front();
        if (out_ch.correlation !== want.correlation ||
            out_ch.root_mean_square_error !== want.root_mean_square_error ||
            out_ch.mean_square_error !== want.mean_square_error ||
            out_ch.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected corr %0d rmse %0d mse %0d status %0d,",
                      " got %0d %0d %0d %0d"},
                     want.correlation, want.root_mean_square_error,
                     want.mean_square_error, want.status, out_ch.correlation,
                     out_ch.root_mean_square_error, out_ch.mean_square_error,
                     out_ch.status);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    pair_row_t pair_rows[$];
    stats_t    none;
    int        items;
    int        pairs;
    int        wait_cycles;

    in_ch.valid <= 1'b0;
    in_ch.real_value <= '0;
    in_ch.predicted_value <= '0;
    in_ch.last_pair <= 1'b0;
    rst_ni = 1'b0;
    clear_sums();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, degenerate sets, perfect and inverse correlation.
    none = '{default: '0};
    pair_rows.push_back('{16'sh7FFF, 16'sh8000, 1'b1, 1'b1,
                          '{16'sd0, 16'd65535, 32'd4294836225, 1'b1}});
    pair_rows.push_back('{16'sh0000, 16'sh0000, 1'b1, 1'b1,
                          '{16'sd0, 16'd0, 32'd0, 1'b1}});
    pair_rows.push_back('{16'sh8000, 16'sh7FFF, 1'b1, 1'b1,
                          '{16'sd0, 16'd65535, 32'd4294836225, 1'b1}});
    pair_rows.push_back('{16'sd0, 16'sd0, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sd1, 16'sd1, 1'b1, 1'b1,
                          '{16'sd16384, 16'd0, 32'd0, 1'b0}});
    pair_rows.push_back('{16'sd0, 16'sd1, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sd1, 16'sd0, 1'b1, 1'b1,
                          '{-16'sd16384, 16'd1, 32'd1, 1'b0}});
    pair_rows.push_back('{16'sd100, 16'sd3, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sd100, -16'sd7, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sd100, 16'sd9, 1'b1, 1'b0, none});
    pair_rows.push_back('{16'sh8000, 16'sh8000, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sd1234, -16'sd4321, 1'b0, 1'b0, none});
    pair_rows.push_back('{-16'sd1, 16'sd1, 1'b1, 1'b0, none});
    pair_rows.push_back('{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, none});
    pair_rows.push_back('{16'sh5555, 16'shAAAA, 1'b1, 1'b0, none});
    foreach (pair_rows[i])
      send_pair(pair_rows[i].real_value, pair_rows[i].predicted_value,
                pair_rows[i].last_pair, pair_rows[i].typed, pair_rows[i].typed_stats);

    // Random sets with idling on both sides.
    idling_on = 1'b1;
    items = 0;
    while (items < 1600) begin
      pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      send_set(pairs, $urandom_range(0, 4));
      items += pairs;
      // hold the sender until every result has come
      if (items > 800 && items - pairs <= 800) begin
        in_ch.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk_i);
      end
    end

    // Last part without idling.
    idling_on = 1'b0;
    while (items < 1700) begin
      pairs = $urandom_range(1, 40);
      send_set(pairs, $urandom_range(0, 4));
      items += pairs;
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_stats.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_stats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
